### sv/ese_pkg.sv
// Package for the encoder speed estimator: widths, register indexes,
// controller states and the command bundle from controller to datapath.
// No dependencies.
package ese_pkg;

  // Width of the free-running time base; elapsed time wraps modulo 2^TIME_BITS.
  localparam int TIME_BITS   = 32;

  localparam int CNT_W       = 8;
  localparam int TS_W        = 32;
  localparam int DELTA_W     = 9;
  localparam int SPEED_W     = 32;
  localparam int GAIN_W      = 32;
  localparam int SPAN_W      = 9;
  localparam int THR_W       = 8;
  localparam int PROD_W      = GAIN_W + DELTA_W;
  localparam int STEP_W      = $clog2(PROD_W);
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Wide enough for raw change plus or minus the largest span.
  localparam int WORK_W      = 11;

  localparam logic [THR_W-1:0]  THR_RESET  = 8'd64;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 9'd256;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WRAP_THRESHOLD = 2'd0,
    CFG_COUNTER_SPAN   = 2'd1,
    CFG_SPEED_GAIN     = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNWRAP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ese_state_t;

  typedef struct packed {
    logic load;      // capture sample, update previous reading and time
    logic unwrap;    // register corrected change and its magnitude
    logic mul;       // register gain times magnitude, clear remainder
    logic div_step;  // one restoring divide step
    logic out_load;  // move the finished result into the output register
  } ese_cmd_t;

endpackage

### sv/ese_ctrl.sv
// Controller state machine of the encoder speed estimator.
// Sequences load, unwrap, multiply, divide and output; owns both handshakes.
// Depends on ese_pkg.
module ese_ctrl import ese_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output ese_cmd_t cmd
);

  ese_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_UNWRAP;
        end
      end
      ST_UNWRAP: begin
        cmd.unwrap = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(PROD_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

### sv/ese_datapath.sv
// Datapath of the encoder speed estimator: configuration registers, sample
// state, unwrap, gain multiply, restoring divider and output register.
// Depends on ese_pkg; driven by ese_ctrl commands.
module ese_datapath import ese_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ese_cmd_t              cmd,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  logic [THR_W-1:0]      wrap_threshold;
  logic [SPAN_W-1:0]     counter_span;
  logic [GAIN_W-1:0]     speed_gain;

  logic [CNT_W-1:0]      last_reading;
  logic [TIME_BITS-1:0]  last_time;

  logic signed [WORK_W-1:0] raw_delta;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  delta_neg;
  logic signed [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0]    mag;

  logic [TIME_BITS-1:0]  rem;
  logic [PROD_W-1:0]     quo;

  logic [DELTA_W-1:0]    out_delta;
  logic [SPEED_W-1:0]    out_speed;
  logic                  out_tv;

  // Input fields.
  logic signed [CNT_W-1:0] counter_value;
  logic [TS_W-1:0]         timestamp_ms;
  logic [TIME_BITS-1:0]    now;

  assign counter_value = $signed(s_tdata[CNT_W-1:0]);
  assign timestamp_ms  = s_tdata[CNT_W +: TS_W];
  assign now           = TIME_BITS'(timestamp_ms);

  // Configuration and sample state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold <= THR_RESET;
      counter_span   <= SPAN_RESET;
      speed_gain     <= GAIN_RESET;
      last_reading   <= '0;
      last_time      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WRAP_THRESHOLD: wrap_threshold <= cfg_data[THR_W-1:0];
          CFG_COUNTER_SPAN:   counter_span   <= cfg_data[SPAN_W-1:0];
          CFG_SPEED_GAIN:     speed_gain     <= cfg_data[GAIN_W-1:0];
          default:            ;
        endcase
      end
      if (cmd.load) begin
        last_reading <= counter_value;
        last_time    <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_delta <= WORK_W'(counter_value) - WORK_W'($signed(last_reading));
      elapsed   <= now - last_time;
    end
  end

  // Unwrap: pick the smaller of change plus span and change minus span when the
  // plain change is too large, ties going to plus; then clamp to nine bits.
  logic signed [WORK_W-1:0] span_s, d_plus, d_minus, chosen;
  logic [WORK_W-1:0]        abs_raw, abs_plus, abs_minus;
  logic signed [DELTA_W-1:0] delta_sat;
  logic signed [DELTA_W:0]   delta_neg_w;

  assign span_s    = $signed(WORK_W'(counter_span));
  assign d_plus    = raw_delta + span_s;
  assign d_minus   = raw_delta - span_s;
  assign abs_raw   = raw_delta[WORK_W-1] ? WORK_W'(-raw_delta) : WORK_W'(raw_delta);
  assign abs_plus  = d_plus[WORK_W-1]    ? WORK_W'(-d_plus)    : WORK_W'(d_plus);
  assign abs_minus = d_minus[WORK_W-1]   ? WORK_W'(-d_minus)   : WORK_W'(d_minus);

  always_comb begin
    if (abs_raw > WORK_W'(wrap_threshold)) begin
      chosen = (abs_plus <= abs_minus) ? d_plus : d_minus;
    end else begin
      chosen = raw_delta;
    end
    if (chosen > WORK_W'(255)) begin
      delta_sat = DELTA_W'(255);
    end else if (chosen < -WORK_W'(256)) begin
      delta_sat = -DELTA_W'(256);
    end else begin
      delta_sat = chosen[DELTA_W-1:0];
    end
  end

  assign delta_neg_w = -(DELTA_W + 1)'(delta_sat);

  always_ff @(posedge clk) begin
    if (cmd.unwrap) begin
      delta     <= delta_sat;
      delta_neg <= delta_sat[DELTA_W-1];
      mag       <= delta_sat[DELTA_W-1] ? delta_neg_w[DELTA_W-1:0] : delta_sat;
    end
  end

  // Restoring divider: the product enters the quotient register and shifts out
  // from the top one bit per step while quotient bits shift in at the bottom.
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   trial_diff;
  logic                 q_bit;

  assign trial      = {rem, quo[PROD_W-1]};
  assign trial_diff = trial - {1'b0, elapsed};
  assign q_bit      = !trial_diff[TIME_BITS];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= '0;
      quo <= PROD_W'(speed_gain) * PROD_W'(mag);
    end else if (cmd.div_step) begin
      rem <= q_bit ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo <= {quo[PROD_W-2:0], q_bit};
    end
  end

  // Sign and saturation of the finished quotient.
  logic [SPEED_W-1:0] speed_sat;
  logic               time_ok;

  assign time_ok = (elapsed != '0);

  always_comb begin
    if (!time_ok) begin
      speed_sat = '0;
    end else if (delta_neg) begin
      if (quo[PROD_W-1:SPEED_W-1] != '0) begin
        speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
        speed_sat = -quo[SPEED_W-1:0];
      end
    end else begin
      if (quo[PROD_W-1:SPEED_W-1] != '0) begin
        speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
      end else begin
        speed_sat = quo[SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_delta <= delta;
      out_speed <= speed_sat;
      out_tv    <= time_ok;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - SPEED_W - DELTA_W)'(0), out_speed, out_delta};
  assign m_tuser = out_tv;

endmodule

### sv/encoder_speed_estimator.sv
// Top level of the encoder speed estimator.
// Instantiates ese_ctrl and ese_datapath; depends on ese_pkg.
//
//   Channel   Direction  Handshake              Contents
//   s_*       in         s_tvalid / s_tready    one counter sample
//   m_*       out        m_tvalid / m_tready    one position change and speed
//   cfg_*     in         cfg_we (no wait)       register write by index
//
// The sample and the previous reading and time are captured at the transfer
// edge. The result then passes through the unwrap, the gain multiply, the
// bit-serial restoring divide of the 41-bit product by the elapsed time, and
// the load of the output register. A new sample is accepted only in the idle
// state, after the result of the last one has been loaded, so samples never
// overlap.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears the previous reading and time. A stalled result waits in the output
// register; the next sample is taken as soon as that result has a place.
//
// Each sample is one signed 8-bit reading of the hardware position counter and
// a millisecond timestamp. The change from the previous reading is unwrapped:
// if its magnitude exceeds wrap_threshold, counter_span is added or subtracted,
// whichever leaves the smaller magnitude, and the result is clamped to nine
// signed bits. Speed is speed_gain (unsigned Q16.16) times the change, divided
// by the elapsed time, truncated toward zero and saturated to signed 32 bits.
// A zero elapsed time gives zero speed and clears the time flag in m_tuser.
module encoder_speed_estimator import ese_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: 0 wrap_threshold, 1 counter_span, 2 speed_gain.
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input samples.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] counter_value, [39:8] timestamp_ms
  // Results.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [8:0] position_delta, [40:9] speed_value
  output logic                   m_tuser    // [0] time_valid
);

  ese_cmd_t cmd;

  // The controller steps through the stages of one sample and owns both
  // handshakes; the datapath only acts on its commands.
  ese_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ese_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### sim/encoder_speed_estimator_test.sv
// Self-checking testbench for encoder_speed_estimator: walks a stimulus table,
// then random counter samples over several register settings.
// Depends on ese_pkg and the encoder_speed_estimator RTL.
`timescale 1ns / 1ps

module encoder_speed_estimator_test;
  import ese_pkg::*;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 212;
  localparam int DRAIN_CYCLES    = 50;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [SPEED_W-1:0] speed;
    logic               time_valid;
  } motion_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] value;
    logic [CNT_W-1:0]      reading;
    logic [TS_W-1:0]       stamp;
    bit                    typed;
    motion_t               motion;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] counter_value, [39:8] timestamp_ms
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [8:0] position_delta, [40:9] speed_value
  logic                   m_tuser;        // [0] time_valid

  encoder_speed_estimator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: the register copies and the previous sample, exactly as
  // the block should hold them after reset.
  logic [THR_W-1:0]  est_threshold = THR_RESET;
  logic [SPAN_W-1:0] est_span      = SPAN_RESET;
  logic [GAIN_W-1:0] est_gain      = GAIN_RESET;
  logic [CNT_W-1:0]  est_last_reading = '0;
  logic [TS_W-1:0]   est_last_stamp   = '0;

  motion_t   expected_motion[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;

  // Sender pacing: a burst of back-to-back transfers, then a random gap.
  int               burst_left = 0;
  logic [CNT_W-1:0] sent_reading = '0;
  logic [TS_W-1:0]  sent_stamp   = '0;

  function automatic int iabs(input int v);
    return v < 0 ? -v : v;
  endfunction

  // Works out the change and speed caused by one sample and advances the
  // stored previous reading and time.
  function automatic motion_t predict_motion(input logic [CNT_W-1:0] reading,
                                             input logic [TS_W-1:0] stamp);
    motion_t         res;
    int              change;
    int              up;
    int              down;
    logic [TS_W-1:0] elapsed;
    longint unsigned product;
    longint unsigned quotient;
    elapsed = stamp - est_last_stamp;
    change  = int'($signed(reading)) - int'($signed(est_last_reading));
    // Unwrap: take whichever of plus or minus the span lands nearer zero;
    // a tie goes to adding.
    if (iabs(change) > int'(est_threshold)) begin
      up     = change + int'(est_span);
      down   = change - int'(est_span);
      change = (iabs(up) <= iabs(down)) ? up : down;
    end
    // Oversized spans can push the change past nine bits.
    if (change > 255) change = 255;
    if (change < -256) change = -256;
    res.delta      = change[DELTA_W-1:0];
    res.time_valid = (elapsed != '0);
    res.speed      = '0;
    if (elapsed != '0) begin
      product  = 64'(est_gain) * 64'(iabs(change));
      quotient = product / 64'(elapsed);
      if (change < 0)
        res.speed = (quotient >= 64'h8000_0000) ? 32'h8000_0000 : -quotient[31:0];
      else
        res.speed = (quotient > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quotient[31:0];
    end
    est_last_reading = reading;
    est_last_stamp   = stamp;
    return res;
  endfunction

  function automatic stim_row_t sample_row(input logic [CNT_W-1:0] reading,
                                           input logic [TS_W-1:0] stamp);
    stim_row_t row;
    row.kind    = ROW_SAMPLE;
    row.index   = '0;
    row.value   = '0;
    row.reading = reading;
    row.stamp   = stamp;
    row.typed   = 1'b0;
    row.motion  = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic [CNT_W-1:0] reading,
                                            input logic [TS_W-1:0] stamp, input int delta,
                                            input logic [SPEED_W-1:0] speed, input bit tv);
    stim_row_t row;
    row = sample_row(reading, stamp);
    row.typed  = 1'b1;
    row.motion = '{delta: delta[DELTA_W-1:0], speed: speed, time_valid: tv};
    return row;
  endfunction

  function automatic stim_row_t config_row(input logic [CFG_ADDR_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = sample_row('0, '0);
    row.kind  = ROW_CONFIG;
    row.index = index;
    row.value = value;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one sample and waits for its transfer. The valid stays high on
  // return so that the next sample of a burst follows without a bubble.
  task automatic send_sample(input logic [CNT_W-1:0] reading, input logic [TS_W-1:0] stamp,
                             input bit typed, input motion_t typed_motion);
    int      gap;
    motion_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, reading};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_motion(reading, stamp);
    expected_motion.push_back(typed ? typed_motion : predicted);
    sent_reading = reading;
    sent_stamp   = stamp;
    burst_left--;
  endtask

  // Holds the sender back until every outstanding result has come out; the
  // registers may only change while the block is idle.
  task automatic wait_for_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_WRAP_THRESHOLD: est_threshold = value[THR_W-1:0];
      CFG_COUNTER_SPAN:   est_span      = value[SPAN_W-1:0];
      CFG_SPEED_GAIN:     est_gain      = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // The receiver stalls on a rotating 16-bit pattern that is replaced each time
  // pattern_age wraps; a quarter of the patterns never stall. Bit 0 is always
  // set, so every pattern lets transfers through.
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age = 0;

  always @(posedge clk) begin
    if (pattern_age == 63) begin
      pattern_age   <= 0;
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end else begin
      pattern_age   <= pattern_age + 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    m_tready <= ready_pattern[0];
  end

  // Every result transfer is checked field by field against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    motion_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_motion.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_tdata), '0);
      end else begin
        want = expected_motion.pop_front();
        if (m_tdata[8:0] !== want.delta)
          report_mismatch("position_delta", 32'(m_tdata[8:0]), 32'(want.delta));
        if (m_tdata[40:9] !== want.speed)
          report_mismatch("speed_value", m_tdata[40:9], want.speed);
        if (m_tuser !== want.time_valid)
          report_mismatch("time_valid", 32'(m_tuser), 32'(want.time_valid));
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] next_reading;
    logic [TS_W-1:0]  next_stamp;
    logic [THR_W-1:0] phase_threshold;
    logic [SPAN_W-1:0] phase_span;
    logic [GAIN_W-1:0] phase_gain;
    int               step;

    // Directed table. Rows with a typed result can be checked by hand; the
    // rest go through the predictor.
    // Right after reset: previous reading and time are zero, so no time passed.
    directed_rows.push_back(checked_row(8'd0, 32'd0, 0, 32'd0, 1'b0));
    directed_rows.push_back(checked_row(8'd10, 32'd1, 10, 32'd655360, 1'b1));
    // A jump of +117 is past the threshold and unwraps to -139.
    directed_rows.push_back(checked_row(8'd127, 32'd2, -139, -32'sd9109504, 1'b1));
    // Same timestamp again: speed is zero but the change still comes out.
    directed_rows.push_back(checked_row(-8'sd128, 32'd2, 1, 32'd0, 1'b0));
    // Timestamp at its top value, then wrapping round to 1 (elapsed 2).
    directed_rows.push_back(checked_row(-8'sd128, 32'hFFFF_FFFF, 0, 32'd0, 1'b1));
    directed_rows.push_back(checked_row(8'd0, 32'd1, -128, -32'sd4194304, 1'b1));
    // Largest gain with no unwrapping: the speed saturates both ways.
    directed_rows.push_back(config_row(CFG_SPEED_GAIN, 32'hFFFF_FFFF));
    directed_rows.push_back(config_row(CFG_WRAP_THRESHOLD, 32'd255));
    directed_rows.push_back(checked_row(8'd127, 32'd2, 127, 32'h7FFF_FFFF, 1'b1));
    directed_rows.push_back(checked_row(-8'sd128, 32'd3, -255, 32'h8000_0000, 1'b1));
    // Zero gain, then a span beyond 256 that drives the change into the clamp.
    directed_rows.push_back(config_row(CFG_SPEED_GAIN, 32'd0));
    directed_rows.push_back(checked_row(8'd5, 32'd1000, 133, 32'd0, 1'b1));
    directed_rows.push_back(config_row(CFG_WRAP_THRESHOLD, 32'd0));
    directed_rows.push_back(config_row(CFG_COUNTER_SPAN, 32'd511));
    directed_rows.push_back(checked_row(8'd6, 32'd1001, -256, 32'd0, 1'b1));
    directed_rows.push_back(checked_row(8'd5, 32'd1002, 255, 32'd0, 1'b1));
    // Span of zero leaves the change as it is; unit gain.
    directed_rows.push_back(config_row(CFG_COUNTER_SPAN, 32'd0));
    directed_rows.push_back(config_row(CFG_SPEED_GAIN, 32'd1));
    directed_rows.push_back(sample_row(-8'sd100, 32'd1003));
    // Span of one, and a write to the unused index that must be ignored.
    directed_rows.push_back(config_row(CFG_COUNTER_SPAN, 32'd1));
    directed_rows.push_back(config_row(CFG_UNUSED_INDEX, 32'hFFFF_FFFF));
    directed_rows.push_back(sample_row(8'd100, 32'd1010));
    // Back to the defaults, the span written with junk in the upper bits;
    // a small negative change checks rounding toward zero.
    directed_rows.push_back(config_row(CFG_COUNTER_SPAN, 32'hFFFF_FF00));
    directed_rows.push_back(config_row(CFG_WRAP_THRESHOLD, 32'd64));
    directed_rows.push_back(config_row(CFG_SPEED_GAIN, 32'd65536));
    directed_rows.push_back(sample_row(8'd93, 32'd1013));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_for_results();
        write_register(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].reading, directed_rows[i].stamp,
                    directed_rows[i].typed, directed_rows[i].motion);
      end
    end

    // Random part: each phase drains the block, sets all three registers,
    // then streams samples that mostly move smoothly, with jumps that trigger
    // unwrapping and timestamps that repeat, wrap or leap.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          phase_threshold = THR_RESET;
          phase_span      = SPAN_RESET;
          phase_gain      = GAIN_RESET;
        end
        1: begin
          phase_threshold = '0;
          phase_span      = 9'd1;
          phase_gain      = 32'hFFFF_FFFF;
        end
        2: begin
          phase_threshold = 8'd255;
          phase_span      = 9'd511;
          phase_gain      = 32'd1;
        end
        3: begin
          phase_threshold = 8'($urandom);
          phase_span      = '0;
          phase_gain      = $urandom;
        end
        4: begin
          phase_threshold = 8'($urandom_range(0, 127));
          phase_span      = 9'd257;
          phase_gain      = GAIN_RESET;
        end
        default: begin
          phase_threshold = 8'($urandom_range(0, 200));
          phase_span      = 9'($urandom_range(1, 256));
          phase_gain      = $urandom >> $urandom_range(0, 31);
        end
      endcase
      wait_for_results();
      write_register(CFG_WRAP_THRESHOLD, {24'($urandom), phase_threshold});
      write_register(CFG_COUNTER_SPAN, {23'($urandom), phase_span});
      write_register(CFG_SPEED_GAIN, phase_gain);

      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1: next_reading = 8'($urandom);
          2: begin
            step = $urandom_range(60, 130);
            if ($urandom_range(0, 1) == 1) step = -step;
            next_reading = sent_reading + 8'(step);
          end
          default: begin
            step = int'($urandom_range(0, 40)) - 20;
            next_reading = sent_reading + 8'(step);
          end
        endcase
        case ($urandom_range(0, 9))
          0: next_stamp = sent_stamp;
          1: next_stamp = $urandom;
          2: next_stamp = 32'hFFFF_FFFF - $urandom_range(0, 8);
          3: next_stamp = sent_stamp + $urandom_range(21, 100000);
          default: next_stamp = sent_stamp + $urandom_range(1, 20);
        endcase
        send_sample(next_reading, next_stamp, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // A correct run takes well under two million ns; this is the hang guard.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
sv/ese_pkg.sv
sv/ese_ctrl.sv
sv/ese_datapath.sv
sv/encoder_speed_estimator.sv
sim/encoder_speed_estimator_test.sv
